// ===== sv/glpd_pkg.sv =====
// Package for the GIF LZW pixel decoder: codes, widths and shared types.
// No dependencies.
package glpd_pkg;

  localparam int DICT_ENTRIES  = 4096;
  localparam int MAX_CODE_BITS = 12;
  localparam int MAX_DIM       = 1024;
  localparam int DICT_AW       = 12;
  localparam int LIT_LIMIT     = 256;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_PUSH  = 2'd1,
    CMD_PULL  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_PIXEL   = 3'd0,
    ST_TAKEN   = 3'd1,
    ST_NEED    = 3'd2,
    ST_FULL    = 3'd3,
    ST_DONE    = 3'd4,
    ST_NOCLEAR = 3'd5,
    ST_BAD     = 3'd6,
    ST_STARTED = 3'd7
  } status_t;

  localparam logic [2:0] CFG_MIN_CODE_SIZE = 3'd0;
  localparam logic [2:0] CFG_IMAGE_WIDTH   = 3'd1;
  localparam logic [2:0] CFG_IMAGE_LEFT    = 3'd2;
  localparam logic [2:0] CFG_IMAGE_TOP     = 3'd3;
  localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd4;
  localparam logic [2:0] CFG_TRANSPARENT   = 3'd5;

endpackage

// ===== sv/glpd_ifs.sv =====
// Valid/ready channel interfaces of the GIF LZW pixel decoder.
// Depends on glpd_pkg.
interface glpd_in_if;
  logic                 valid;
  logic                 ready;
  glpd_pkg::cmd_t       command;
  logic [7:0]           data_byte;
  modport source (output valid, command, data_byte, input ready);
  modport sink   (input valid, command, data_byte, output ready);
endinterface

interface glpd_out_if;
  logic                 valid;
  logic                 ready;
  glpd_pkg::status_t    status;
  logic [7:0]           pixel_index;
  logic                 pixel_write;
  logic [19:0]          pixel_address;
  modport source (output valid, status, pixel_index, pixel_write, pixel_address, input ready);
  modport sink   (input valid, status, pixel_index, pixel_write, pixel_address, output ready);
endinterface

interface glpd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [10:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/glpd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module glpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/gif_lzw_pixel_decoder_top.sv =====
// GIF LZW pixel decoder, top level: command sequencer, dictionary walk and pixel placement.
// Depends on glpd_pkg, glpd_ifs, glpd_ram.
//
// Start and push commands answer in the cycle after they are taken. A pull with a pixel
// stacked passes S_FETCH, S_POP and S_EMIT; otherwise S_FETCH reads each code, the first
// code after a clear is stacked by its read, and any other code walks its dictionary chain
// (S_WALK and S_WALK_RD per entry, registered RAM read; S_WALK for the root literal); then
// S_POP and S_EMIT pop the pixel and place it. The block takes one command at a time and
// accepts the next once the previous result has been transferred. No clearing pass is needed.
module gif_lzw_pixel_decoder_top (
  input  logic                clk,
  input  logic                rst_n,
  glpd_in_if.sink             in_ch,
  glpd_out_if.source          out_ch,
  glpd_cfg_if.sink            cfg_ch
);
  import glpd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_WALK, S_WALK_RD, S_POP, S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    PH_IDLE, PH_LEAD, PH_FIRST, PH_NEXT, PH_DONE, PH_NOCLEAR, PH_BAD
  } phase_t;

  state_t      state_r, state_nxt;
  phase_t      phase_r, phase_nxt;
  logic [23:0] bitbuf_r, bitbuf_nxt;
  logic [4:0]  bitcnt_r, bitcnt_nxt;
  logic [12:0] next_code_r, next_code_nxt;
  logic [3:0]  code_size_r, code_size_nxt;
  logic [11:0] prev_code_r, prev_code_nxt;
  logic [7:0]  old_first_r, old_first_nxt;
  logic [12:0] stack_count_r, stack_count_nxt;
  logic [10:0] col_r, col_nxt;
  logic [9:0]  row_r, row_nxt;
  logic [11:0] walk_code_r, walk_code_nxt;
  logic [11:0] cur_code_r, cur_code_nxt;
  logic [19:0] prod_r, prod_nxt;

  logic        out_valid_r, out_valid_nxt;
  status_t     out_status_r, out_status_nxt;
  logic [7:0]  out_px_r, out_px_nxt;
  logic        out_wr_r, out_wr_nxt;
  logic [19:0] out_addr_r, out_addr_nxt;

  logic [3:0]  min_code_size_r;
  logic [10:0] image_width_r, screen_width_r;
  logic [9:0]  image_left_r, image_top_r;
  logic [8:0]  transparent_r;

  logic [3:0]  eff_mcs;
  logic [12:0] clear_code;
  logic [23:0] code_mask;
  logic [11:0] code;
  logic [12:0] code_ext;
  logic        in_fire;

  logic        push_en;
  logic [7:0]  push_data;
  logic        dict_we;
  logic [19:0] dict_rdata;
  logic [7:0]  stack_rdata;
  logic [12:0] nc_inc;
  logic [10:0] col_inc;
  logic [21:0] prod_full;

  assign in_ch.ready          = (state_r == S_IDLE) && !out_valid_r;
  assign in_fire              = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready         = 1'b1;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.pixel_index   = out_px_r;
  assign out_ch.pixel_write   = out_wr_r;
  assign out_ch.pixel_address = out_addr_r;

  assign eff_mcs    = (min_code_size_r < 4'd2) ? 4'd2 :
                      (min_code_size_r > 4'd8) ? 4'd8 : min_code_size_r;
  assign clear_code = 13'd1 << eff_mcs;
  assign code_mask  = (24'd1 << code_size_r) - 24'd1;
  assign code       = 12'(bitbuf_r & code_mask);
  assign code_ext   = {1'b0, code};
  assign prod_full  = (11'({1'b0, image_top_r} + {1'b0, row_r})) * screen_width_r;

  glpd_ram #(.WIDTH(20), .DEPTH(DICT_ENTRIES)) u_dict (
    .clk   (clk),
    .we    (dict_we),
    .waddr (next_code_r[DICT_AW-1:0]),
    .wdata ({prev_code_r, walk_code_r[7:0]}),
    .raddr (walk_code_r),
    .rdata (dict_rdata)
  );

  glpd_ram #(.WIDTH(8), .DEPTH(DICT_ENTRIES)) u_stack (
    .clk   (clk),
    .we    (push_en && (stack_count_r < 13'(DICT_ENTRIES))),
    .waddr (stack_count_r[DICT_AW-1:0]),
    .wdata (push_data),
    .raddr (12'(stack_count_r - 13'd1)),
    .rdata (stack_rdata)
  );

  always_comb begin
    state_nxt       = state_r;
    phase_nxt       = phase_r;
    bitbuf_nxt      = bitbuf_r;
    bitcnt_nxt      = bitcnt_r;
    next_code_nxt   = next_code_r;
    code_size_nxt   = code_size_r;
    prev_code_nxt   = prev_code_r;
    old_first_nxt   = old_first_r;
    stack_count_nxt = stack_count_r;
    col_nxt         = col_r;
    row_nxt         = row_r;
    walk_code_nxt   = walk_code_r;
    cur_code_nxt    = cur_code_r;
    prod_nxt        = prod_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_status_nxt  = out_status_r;
    out_px_nxt      = out_px_r;
    out_wr_nxt      = out_wr_r;
    out_addr_nxt    = out_addr_r;
    push_en         = 1'b0;
    push_data       = 8'd0;
    dict_we         = 1'b0;
    nc_inc          = next_code_r;
    col_inc         = col_r + 11'd1;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          out_px_nxt   = 8'd0;
          out_wr_nxt   = 1'b0;
          out_addr_nxt = 20'd0;
          case (in_ch.command)
            CMD_START: begin
              bitbuf_nxt      = 24'd0;
              bitcnt_nxt      = 5'd0;
              stack_count_nxt = 13'd0;
              col_nxt         = 11'd0;
              row_nxt         = 10'd0;
              prev_code_nxt   = 12'd0;
              old_first_nxt   = 8'd0;
              next_code_nxt   = clear_code + 13'd2;
              code_size_nxt   = eff_mcs + 4'd1;
              phase_nxt       = PH_LEAD;
              out_valid_nxt   = 1'b1;
              out_status_nxt  = ST_STARTED;
            end
            CMD_PUSH: begin
              out_valid_nxt = 1'b1;
              if (bitcnt_r > 5'd16) begin
                out_status_nxt = ST_FULL;
              end else begin
                bitbuf_nxt     = bitbuf_r | 24'({16'd0, in_ch.data_byte} << bitcnt_r);
                bitcnt_nxt     = bitcnt_r + 5'd8;
                out_status_nxt = ST_TAKEN;
              end
            end
            CMD_PULL: begin
              state_nxt = S_FETCH;
            end
            default: begin
            end
          endcase
        end
      end
      S_FETCH: begin
        if (stack_count_r != 13'd0) begin
          state_nxt = S_POP;
        end else if (phase_r == PH_IDLE || phase_r == PH_DONE) begin
          out_valid_nxt = 1'b1; out_status_nxt = ST_DONE; state_nxt = S_IDLE;
        end else if (phase_r == PH_NOCLEAR) begin
          out_valid_nxt = 1'b1; out_status_nxt = ST_NOCLEAR; state_nxt = S_IDLE;
        end else if (phase_r == PH_BAD) begin
          out_valid_nxt = 1'b1; out_status_nxt = ST_BAD; state_nxt = S_IDLE;
        end else if ({1'b0, bitcnt_r} < code_size_r) begin
          out_valid_nxt = 1'b1; out_status_nxt = ST_NEED; state_nxt = S_IDLE;
        end else begin
          bitbuf_nxt = bitbuf_r >> code_size_r;
          bitcnt_nxt = bitcnt_r - {1'b0, code_size_r};
          case (phase_r)
            PH_LEAD: begin
              if (code_ext != clear_code) begin
                phase_nxt = PH_NOCLEAR;
              end else begin
                next_code_nxt = clear_code + 13'd2;
                code_size_nxt = eff_mcs + 4'd1;
                phase_nxt     = PH_FIRST;
              end
            end
            PH_FIRST: begin
              if (code_ext == clear_code) begin
                phase_nxt = PH_FIRST;
              end else if (code_ext == clear_code + 13'd1) begin
                phase_nxt = PH_DONE;
              end else if (code_ext > clear_code) begin
                phase_nxt = PH_BAD;
              end else begin
                push_en         = 1'b1;
                push_data       = code[7:0];
                stack_count_nxt = stack_count_r + 13'd1;
                prev_code_nxt   = code;
                old_first_nxt   = code[7:0];
                phase_nxt       = PH_NEXT;
                state_nxt       = S_POP;
              end
            end
            default: begin
              if (code_ext == clear_code) begin
                next_code_nxt = clear_code + 13'd2;
                code_size_nxt = eff_mcs + 4'd1;
                phase_nxt     = PH_FIRST;
              end else if (code_ext == clear_code + 13'd1) begin
                phase_nxt = PH_DONE;
              end else if (code_ext > next_code_r) begin
                phase_nxt = PH_BAD;
              end else begin
                cur_code_nxt = code;
                state_nxt    = S_WALK;
                if (code_ext == next_code_r) begin
                  push_en         = 1'b1;
                  push_data       = old_first_r;
                  stack_count_nxt = stack_count_r + 13'd1;
                  walk_code_nxt   = prev_code_r;
                end else begin
                  walk_code_nxt = code;
                end
              end
            end
          endcase
        end
      end
      S_WALK: begin
        if ({1'b0, walk_code_r} >= clear_code) begin
          state_nxt = S_WALK_RD;
        end else begin
          push_en   = 1'b1;
          push_data = walk_code_r[7:0];
          if (stack_count_r < 13'(DICT_ENTRIES)) begin
            stack_count_nxt = stack_count_r + 13'd1;
          end
          if (next_code_r < 13'(DICT_ENTRIES)) begin
            dict_we = 1'b1;
            nc_inc  = next_code_r + 13'd1;
          end
          next_code_nxt = nc_inc;
          if (code_size_r < 4'(MAX_CODE_BITS) && nc_inc == (13'd1 << code_size_r)) begin
            code_size_nxt = code_size_r + 4'd1;
          end
          prev_code_nxt = cur_code_r;
          old_first_nxt = walk_code_r[7:0];
          state_nxt     = S_POP;
        end
      end
      S_WALK_RD: begin
        push_en   = 1'b1;
        push_data = dict_rdata[7:0];
        if (stack_count_r < 13'(DICT_ENTRIES)) begin
          stack_count_nxt = stack_count_r + 13'd1;
        end
        walk_code_nxt = dict_rdata[19:8];
        state_nxt     = S_WALK;
      end
      S_POP: begin
        stack_count_nxt = stack_count_r - 13'd1;
        prod_nxt        = prod_full[19:0];
        state_nxt       = S_EMIT;
      end
      S_EMIT: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_PIXEL;
        out_px_nxt     = stack_rdata;
        out_wr_nxt     = {1'b0, stack_rdata} != transparent_r;
        out_addr_nxt   = prod_r + {10'd0, image_left_r} + {9'd0, col_r};
        if (col_inc >= image_width_r) begin
          col_nxt = 11'd0;
          row_nxt = (row_r == 10'(MAX_DIM - 1)) ? 10'd0 : row_r + 10'd1;
        end else begin
          col_nxt = col_inc;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      phase_r         <= PH_IDLE;
      bitbuf_r        <= 24'd0;
      bitcnt_r        <= 5'd0;
      next_code_r     <= 13'd0;
      code_size_r     <= 4'd9;
      prev_code_r     <= 12'd0;
      old_first_r     <= 8'd0;
      stack_count_r   <= 13'd0;
      col_r           <= 11'd0;
      row_r           <= 10'd0;
      out_valid_r     <= 1'b0;
      min_code_size_r <= 4'd8;
      image_width_r   <= 11'd1;
      image_left_r    <= 10'd0;
      image_top_r     <= 10'd0;
      screen_width_r  <= 11'd1;
      transparent_r   <= 9'd256;
    end else begin
      state_r       <= state_nxt;
      phase_r       <= phase_nxt;
      bitbuf_r      <= bitbuf_nxt;
      bitcnt_r      <= bitcnt_nxt;
      next_code_r   <= next_code_nxt;
      code_size_r   <= code_size_nxt;
      prev_code_r   <= prev_code_nxt;
      old_first_r   <= old_first_nxt;
      stack_count_r <= stack_count_nxt;
      col_r         <= col_nxt;
      row_r         <= row_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          CFG_MIN_CODE_SIZE: min_code_size_r <= cfg_ch.data[3:0];
          CFG_IMAGE_WIDTH:   image_width_r   <= cfg_ch.data;
          CFG_IMAGE_LEFT:    image_left_r    <= cfg_ch.data[9:0];
          CFG_IMAGE_TOP:     image_top_r     <= cfg_ch.data[9:0];
          CFG_SCREEN_WIDTH:  screen_width_r  <= cfg_ch.data;
          CFG_TRANSPARENT:   transparent_r   <= cfg_ch.data[8:0];
          default: begin
          end
        endcase
      end
    end
    walk_code_r  <= walk_code_nxt;
    cur_code_r   <= cur_code_nxt;
    prod_r       <= prod_nxt;
    out_status_r <= out_status_nxt;
    out_px_r     <= out_px_nxt;
    out_wr_r     <= out_wr_nxt;
    out_addr_r   <= out_addr_nxt;
  end

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stack_count_r <= 13'(DICT_ENTRIES)) else $error("stack count overflow");

  a_dict_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_code_r <= 13'(DICT_ENTRIES)) else $error("next code beyond dictionary");

  a_code_size: assert property (@(posedge clk) disable iff (!rst_n)
    code_size_r >= 4'd3 && code_size_r <= 4'(MAX_CODE_BITS))
    else $error("code size out of range");

  a_start_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.command == CMD_START) |=> (out_valid_r && out_status_r == ST_STARTED))
    else $error("start not acknowledged");

endmodule

// ===== bench/glpd_pixel_checker.sv =====
// Watches the configuration, command and pixel channels of the GIF LZW pixel decoder.
// It predicts every result and compares it with what the decoder returns.
// Depends on glpd_pkg and glpd_ifs.
module glpd_pixel_checker
  import glpd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  glpd_in_if    in_mon,
  glpd_out_if   out_mon,
  glpd_cfg_if   cfg_mon,
  output int    fail_count,
  output int    pending
);

  typedef struct packed {
    status_t     status;
    logic [7:0]  index;
    logic        write;
    logic [19:0] address;
  } pixel_result_t;

  typedef enum int {PH_IDLE, PH_LEAD, PH_FIRST, PH_NEXT, PH_DONE, PH_NOCLEAR, PH_BAD} phase_t;

  pixel_result_t pixel_q[$];

  logic [3:0]  r_mcs;
  logic [10:0] r_width;
  logic [9:0]  r_left;
  logic [9:0]  r_top;
  logic [10:0] r_pitch;
  logic [8:0]  r_transp;

  logic [23:0] bitbuf;
  int unsigned nbits, next_code, code_size, prev_code, old_first;
  int unsigned stack_cnt, col, row;
  phase_t      phase;
  logic [11:0] dict_pfx [DICT_ENTRIES];
  logic [7:0]  dict_sfx [DICT_ENTRIES];
  logic [7:0]  char_stack [DICT_ENTRIES];

  function automatic int unsigned lzw_root_bits();
    if (r_mcs < 2) return 2;
    if (r_mcs > 8) return 8;
    return r_mcs;
  endfunction

  function automatic void stack_char(int unsigned c);
    if (stack_cnt < DICT_ENTRIES) begin
      char_stack[stack_cnt] = c[7:0];
      stack_cnt++;
    end
  endfunction

  function automatic int unsigned unwind_chain(int unsigned code, int unsigned clear);
    int unsigned steps;
    steps = 0;
    code &= DICT_ENTRIES - 1;
    while (code >= clear && steps < DICT_ENTRIES) begin
      stack_char(dict_sfx[code]);
      code = dict_pfx[code];
      steps++;
    end
    stack_char(code);
    return code & 8'hFF;
  endfunction

  function automatic void restart_table(int unsigned clear);
    next_code = clear + 2;
    code_size = lzw_root_bits() + 1;
  endfunction

  // returns -1 once a pixel is stacked, otherwise the status to answer
  function automatic int decode_until_pixel();
    int unsigned clear, code, first;
    clear = 1 << lzw_root_bits();
    while (stack_cnt == 0) begin
      case (phase)
        PH_IDLE, PH_DONE: return ST_DONE;
        PH_NOCLEAR:       return ST_NOCLEAR;
        PH_BAD:           return ST_BAD;
        default: ;
      endcase
      if (nbits < code_size) return ST_NEED;
      code = bitbuf & ((1 << code_size) - 1);
      bitbuf = bitbuf >> code_size;
      nbits -= code_size;
      if (phase == PH_LEAD) begin
        if (code != clear) begin
          phase = PH_NOCLEAR;
        end else begin
          restart_table(clear);
          phase = PH_FIRST;
        end
      end else if (phase == PH_FIRST) begin
        if (code == clear + 1) phase = PH_DONE;
        else if (code > clear) phase = PH_BAD;
        else if (code != clear) begin
          stack_char(code);
          prev_code = code;
          old_first = code & 8'hFF;
          phase = PH_NEXT;
        end
      end else if (code == clear) begin
        restart_table(clear);
        phase = PH_FIRST;
      end else if (code == clear + 1) begin
        phase = PH_DONE;
      end else if (code > next_code) begin
        phase = PH_BAD;
      end else begin
        if (code == next_code) begin
          stack_char(old_first);
          first = unwind_chain(prev_code, clear);
        end else begin
          first = unwind_chain(code, clear);
        end
        if (next_code < DICT_ENTRIES) begin
          dict_pfx[next_code] = prev_code[11:0];
          dict_sfx[next_code] = first[7:0];
          next_code++;
        end
        if (code_size < MAX_CODE_BITS && next_code == (1 << code_size)) code_size++;
        prev_code = code & (DICT_ENTRIES - 1);
        old_first = first;
      end
    end
    return -1;
  endfunction

  function automatic pixel_result_t predict_command(cmd_t c, logic [7:0] b);
    pixel_result_t r;
    int st;
    int unsigned addr;
    r = '0;
    case (c)
      CMD_START: begin
        bitbuf = '0; nbits = 0; stack_cnt = 0; col = 0; row = 0;
        prev_code = 0; old_first = 0;
        restart_table(1 << lzw_root_bits());
        phase = PH_LEAD;
        r.status = ST_STARTED;
      end
      CMD_PUSH: begin
        if (nbits > 16) begin
          r.status = ST_FULL;
        end else begin
          bitbuf = bitbuf | (24'(b) << nbits);
          nbits += 8;
          r.status = ST_TAKEN;
        end
      end
      default: begin
        st = decode_until_pixel();
        if (st >= 0) begin
          r.status = status_t'(st);
        end else begin
          stack_cnt--;
          r.status = ST_PIXEL;
          r.index = char_stack[stack_cnt & (DICT_ENTRIES - 1)];
          r.write = ({1'b0, r.index} != r_transp);
          addr = (r_top + row) * r_pitch + r_left + col;
          r.address = addr[19:0];
          col++;
          if (col >= r_width) begin
            col = 0;
            row = (row + 1 >= MAX_DIM) ? 0 : row + 1;
          end
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    pixel_result_t want, got;
    if (!rst_n) begin
      r_mcs = 8; r_width = 1; r_left = 0; r_top = 0; r_pitch = 1; r_transp = 256;
      bitbuf = '0; nbits = 0; next_code = 0; code_size = 9; prev_code = 0; old_first = 0;
      stack_cnt = 0; col = 0; row = 0; phase = PH_IDLE;
      foreach (dict_pfx[i]) begin
        dict_pfx[i] = '0; dict_sfx[i] = '0; char_stack[i] = '0;
      end
      pixel_q.delete();
      fail_count <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.status, out_mon.pixel_index, out_mon.pixel_write, out_mon.pixel_address};
        if (pixel_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result transfer: %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = pixel_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("mismatch: expected %s idx %0d wr %0d addr %0h, got %s idx %0d wr %0d addr %0h",
                       want.status.name(), want.index, want.write, want.address,
                       got.status.name(), got.index, got.write, got.address);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_MIN_CODE_SIZE: r_mcs    = cfg_mon.data[3:0];
          CFG_IMAGE_WIDTH:   r_width  = cfg_mon.data;
          CFG_IMAGE_LEFT:    r_left   = cfg_mon.data[9:0];
          CFG_IMAGE_TOP:     r_top    = cfg_mon.data[9:0];
          CFG_SCREEN_WIDTH:  r_pitch  = cfg_mon.data;
          CFG_TRANSPARENT:   r_transp = cfg_mon.data[8:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready && in_mon.command != CMD_NONE)
        pixel_q.push_back(predict_command(in_mon.command, in_mon.data_byte));
    end
    pending <= pixel_q.size();
  end

endmodule

// ===== bench/tb_gif_lzw_pixel_decoder_top.sv =====
// Testbench top for the GIF LZW pixel decoder: clock, reset, LZW stream stimulus,
// configuration phases and the verdict. Depends on glpd_pkg, glpd_ifs, the decoder
// top level and glpd_pixel_checker.
module tb_gif_lzw_pixel_decoder_top;
  import glpd_pkg::*;

  typedef enum int {
    FR_GOOD, FR_OPEN, FR_NOCLEAR, FR_BEYOND, FR_FIRST_BAD, FR_NOISE, FR_DOUBLE_CLEAR
  } frame_kind_t;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count, pending;
  int   sent, got, hold_cycles, idle_left;
  bit   quiet;
  status_t last_status;
  int unsigned cur_mcs;
  logic [7:0] lzw_bytes[$];
  int unsigned pack_acc, pack_bits;

  glpd_in_if  in_ch();
  glpd_out_if out_ch();
  glpd_cfg_if cfg_ch();

  gif_lzw_pixel_decoder_top DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  glpd_pixel_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch), .cfg_mon(cfg_ch),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #200_000_000;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      got <= 0;
      idle_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got <= got + 1;
        last_status <= out_ch.status;
      end
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles <= hold_cycles - 1;
      end else if (idle_left > 0) begin
        out_ch.ready <= 1'b0;
        idle_left--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        idle_left = $urandom_range(0, 5);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic offer(cmd_t c, logic [7:0] b, bit keep);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= c;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    if (c != CMD_NONE) sent++;
    if (!keep) in_ch.valid <= 1'b0;
  endtask

  task automatic wait_results();
    while (got < sent) @(posedge clk);
  endtask

  task automatic command(cmd_t c, logic [7:0] b);
    offer(c, b, 1'b0);
    if (c == CMD_NONE) repeat (2) @(posedge clk);
    else wait_results();
  endtask

  task automatic write_reg(logic [2:0] idx, logic [10:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    if (idx == CFG_MIN_CODE_SIZE) cur_mcs = (val[3:0] < 2) ? 2 : (val[3:0] > 8) ? 8 : val[3:0];
  endtask

  function automatic logic [10:0] pick(int lo, int hi);
    case ($urandom_range(0, 4))
      0: return lo;
      1: return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  task automatic random_setup();
    repeat (4) @(posedge clk);
    write_reg(CFG_MIN_CODE_SIZE, pick(0, 15));
    write_reg(CFG_IMAGE_WIDTH, pick(0, 2047));
    write_reg(CFG_IMAGE_LEFT, pick(0, 1023));
    write_reg(CFG_IMAGE_TOP, pick(0, 1023));
    write_reg(CFG_SCREEN_WIDTH, pick(0, 2047));
    write_reg(CFG_TRANSPARENT, ($urandom_range(0, 2) == 0) ? pick(256, 511) : pick(0, 255));
  endtask

  function automatic void put_code(int unsigned code, int unsigned width);
    pack_acc |= (code & ((1 << width) - 1)) << pack_bits;
    pack_bits += width;
    while (pack_bits >= 8) begin
      lzw_bytes.push_back(pack_acc[7:0]);
      pack_acc >>= 8;
      pack_bits -= 8;
    end
  endfunction

  // code stream that tracks the decoder's table size and code width
  function automatic void build_stream(frame_kind_t kind, int n);
    int unsigned clear, nc, cs, code;
    bit first;
    lzw_bytes.delete();
    pack_acc = 0;
    pack_bits = 0;
    if (kind == FR_NOISE) begin
      repeat (n) lzw_bytes.push_back($urandom_range(0, 255));
      return;
    end
    clear = 1 << cur_mcs;
    nc = clear + 2;
    cs = cur_mcs + 1;
    first = 1;
    put_code((kind == FR_NOCLEAR) ? $urandom_range(0, clear - 1) : clear, cs);
    if (kind == FR_DOUBLE_CLEAR) put_code(clear, cs);
    for (int i = 0; i < n; i++) begin
      if (first) begin
        code = (kind == FR_FIRST_BAD && i == 0) ? clear + 2 : $urandom_range(0, clear - 1);
        put_code(code, cs);
        first = 0;
        continue;
      end
      if ($urandom_range(0, 99) < 3) begin
        put_code(clear, cs);
        nc = clear + 2;
        cs = cur_mcs + 1;
        first = 1;
        continue;
      end
      if (kind == FR_BEYOND && i == n - 1) code = nc + 1;
      else if ($urandom_range(0, 99) < 55) code = $urandom_range(0, clear - 1);
      else code = $urandom_range(clear + 2, (nc < DICT_ENTRIES) ? nc : DICT_ENTRIES - 1);
      put_code(code, cs);
      if (nc < DICT_ENTRIES) nc++;
      if (cs < MAX_CODE_BITS && nc == (1 << cs)) cs++;
    end
    if (kind != FR_OPEN) put_code(clear + 1, cs);
    if (pack_bits > 0) lzw_bytes.push_back(pack_acc[7:0]);
  endfunction

  task automatic run_frame(frame_kind_t kind, int n);
    int idx;
    status_t pull_st;
    build_stream(kind, n);
    command(CMD_START, 8'h00);
    idx = 0;
    pull_st = ST_NEED;
    forever begin
      if ($urandom_range(0, 99) == 0) command(CMD_NONE, $urandom_range(0, 255));
      if (idx < lzw_bytes.size() && (pull_st == ST_NEED || $urandom_range(0, 2) == 0)) begin
        command(CMD_PUSH, lzw_bytes[idx]);
        if (last_status == ST_TAKEN) idx++;
        else pull_st = ST_PIXEL;
      end else begin
        command(CMD_PULL, $urandom_range(0, 255));
        pull_st = last_status;
        if (pull_st inside {ST_DONE, ST_NOCLEAR, ST_BAD}) break;
        if (pull_st == ST_NEED && idx >= lzw_bytes.size()) break;
      end
    end
  endtask

  initial begin
    int start_sent;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.command <= CMD_START;
    in_ch.data_byte <= 8'h00;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_MIN_CODE_SIZE;
    cfg_ch.data <= '0;
    hold_cycles <= 0;
    quiet = 0;
    cur_mcs = 8;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    command(CMD_PULL, 8'h00);
    command(CMD_NONE, 8'hFF);
    command(CMD_PUSH, 8'hFF);
    run_frame(FR_GOOD, 6);
    write_reg(CFG_MIN_CODE_SIZE, 11'd2);
    write_reg(CFG_IMAGE_WIDTH, 11'd0);
    write_reg(CFG_IMAGE_LEFT, 11'd1023);
    write_reg(CFG_IMAGE_TOP, 11'd1023);
    write_reg(CFG_SCREEN_WIDTH, 11'd2047);
    write_reg(CFG_TRANSPARENT, 11'd3);
    run_frame(FR_DOUBLE_CLEAR, 6);
    run_frame(FR_NOCLEAR, 2);
    run_frame(FR_FIRST_BAD, 3);
    run_frame(FR_BEYOND, 5);
    write_reg(CFG_MIN_CODE_SIZE, 11'd15);
    run_frame(FR_OPEN, 4);

    // stall the result side while pulls keep coming
    command(CMD_START, 8'h00);
    repeat (4) command(CMD_PUSH, $urandom_range(0, 255));
    hold_cycles <= 80;
    repeat (3) offer(CMD_PULL, 8'h00, 1'b1);
    offer(CMD_PULL, 8'h00, 1'b0);
    wait_results();

    write_reg(CFG_MIN_CODE_SIZE, 11'd2);
    write_reg(CFG_IMAGE_WIDTH, 11'd1024);
    write_reg(CFG_SCREEN_WIDTH, 11'd1024);
    write_reg(CFG_TRANSPARENT, 11'd256);
    run_frame(FR_GOOD, 40);

    start_sent = sent;
    while (sent - start_sent < 1650) begin
      if (sent - start_sent > 1350) quiet = 1;
      random_setup();
      case ($urandom_range(0, 19))
        0: run_frame(FR_NOISE, $urandom_range(1, 12));
        1: run_frame(FR_NOCLEAR, $urandom_range(1, 6));
        2: run_frame(FR_FIRST_BAD, $urandom_range(1, 6));
        3: run_frame(FR_BEYOND, $urandom_range(2, 30));
        4: run_frame(FR_DOUBLE_CLEAR, $urandom_range(2, 30));
        5, 6, 7: run_frame(FR_OPEN, $urandom_range(2, 40));
        8: run_frame(FR_GOOD, 60);
        default: run_frame(FR_GOOD, $urandom_range(2, 40));
      endcase
    end

    while (pending != 0 || got < sent) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
